FILE: rtl/tnmh_pkg.sv
// Shared constants, types and control structs for the top-N min-heap core.
package tnmh_pkg;

    localparam int HEAP_DEPTH = 512;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 10;
    localparam int RIDX_W     = 9;
    localparam int OP_W       = 2;

    localparam logic [CFG_W-1:0] HEAP_SIZE_RESET = CFG_W'(512);

    localparam logic [OP_W-1:0] OP_OFFER   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_HLOAD,
        ST_HCAP,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_SIFT_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic fill_wr;
        logic set_built;
        logic heap_init;
        logic sift_start;
        logic restart;
        logic rd_issue;
        logic rd_capture;
        logic load_read_k;
        logic cap_held;
        logic kid_issue;
        logic leaf_wr;
        logic child_step;
        logic k_dec;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            built;
        logic            fill_last;
        logic            size_ge2;
        logic            greater;
        logic            kid_ok;
        logic            child_lt;
        logic            k_zero;
        logic            heapify;
    } status_t;

endpackage

FILE: rtl/tnmh_ram.sv
// Generic RAM: one write port, two registered read ports.
module tnmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/tnmh_dp.sv
// Datapath: heap store, fill/build state, sift-down registers and result register.
module tnmh_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [tnmh_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic [tnmh_pkg::OP_W-1:0]            s_op,
    input  logic signed [tnmh_pkg::DATA_W-1:0]   s_value,
    input  logic [tnmh_pkg::RIDX_W-1:0]          s_read_index,
    input  tnmh_pkg::cmd_t                       cmd,
    output tnmh_pkg::status_t                    status,
    output logic signed [tnmh_pkg::DATA_W-1:0]   m_read_value,
    output logic                                 m_accepted,
    output logic signed [tnmh_pkg::DATA_W-1:0]   m_heap_min,
    output logic                                 m_heap_ready
);

    localparam int AW = tnmh_pkg::ADDR_W;
    localparam int SW = tnmh_pkg::SIZE_W;
    localparam int DW = tnmh_pkg::DATA_W;

    logic [tnmh_pkg::CFG_W-1:0]  heap_size_reg, heap_size_next;
    logic [SW-1:0]               fill_reg, fill_next;
    logic                        built_reg, built_next;
    logic signed [DW-1:0]        root_reg, root_next;
    logic [tnmh_pkg::OP_W-1:0]   op_reg;
    logic signed [DW-1:0]        val_reg;
    logic [tnmh_pkg::RIDX_W-1:0] idx_reg;
    logic signed [DW-1:0]        held_reg;
    logic [AW-1:0]               pos_reg;
    logic [AW-1:0]               k_reg;
    logic                        heapify_reg;
    logic                        acc_reg;
    logic signed [DW-1:0]        rd_val_reg;
    logic signed [DW-1:0]        out_rd_reg, out_min_reg;
    logic                        out_acc_reg, out_ready_reg;

    logic [SW-1:0]     n_used;
    logic [SW-1:0]     n_half;
    logic [SW:0]       kid_l, kid_r;
    logic              right_ok;
    logic signed [DW-1:0] kid_a, kid_b, child_val;
    logic [AW-1:0]     child_pos;

    logic              ram_we, ram_re_a;
    logic [AW-1:0]     ram_waddr, ram_raddr_a;
    logic [DW-1:0]     ram_wdata, ram_rdata_a, ram_rdata_b;

    // size in use, saturated into 1..HEAP_DEPTH
    always_comb begin
        if (heap_size_reg == '0) begin
            n_used = SW'(1);
        end else if (32'(heap_size_reg) > tnmh_pkg::HEAP_DEPTH) begin
            n_used = SW'(tnmh_pkg::HEAP_DEPTH);
        end else begin
            n_used = SW'(heap_size_reg);
        end
    end

    assign n_half   = n_used >> 1;
    assign kid_l    = {1'b0, pos_reg, 1'b1};
    assign kid_r    = kid_l + (SW+1)'(1);
    assign right_ok = kid_r < {1'b0, n_used};

    assign kid_a = $signed(ram_rdata_a);
    assign kid_b = $signed(ram_rdata_b);

    always_comb begin
        if (right_ok && (kid_b < kid_a)) begin
            child_val = kid_b;
            child_pos = kid_r[AW-1:0];
        end else begin
            child_val = kid_a;
            child_pos = kid_l[AW-1:0];
        end
    end

    // RAM port steering
    assign ram_we   = cmd.fill_wr | cmd.leaf_wr | cmd.child_step;
    assign ram_re_a = cmd.rd_issue | cmd.load_read_k | cmd.kid_issue;

    always_comb begin
        if (cmd.fill_wr) begin
            ram_waddr = fill_reg[AW-1:0];
            ram_wdata = val_reg;
        end else if (cmd.child_step) begin
            ram_waddr = pos_reg;
            ram_wdata = child_val;
        end else begin
            ram_waddr = pos_reg;
            ram_wdata = held_reg;
        end
    end

    always_comb begin
        if (cmd.rd_issue) begin
            ram_raddr_a = AW'(idx_reg);
        end else if (cmd.load_read_k) begin
            ram_raddr_a = k_reg;
        end else begin
            ram_raddr_a = kid_l[AW-1:0];
        end
    end

    tnmh_ram #(
        .WIDTH (DW),
        .DEPTH (tnmh_pkg::HEAP_DEPTH)
    ) u_heap_ram (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .re_b    (cmd.kid_issue),
        .raddr_b (kid_r[AW-1:0]),
        .rdata_b (ram_rdata_b)
    );

    // control state: size, fill count, built flag
    always_comb begin
        heap_size_next = heap_size_reg;
        fill_next      = fill_reg;
        built_next     = built_reg;
        if (cfg_wr_en) begin
            heap_size_next = cfg_wr_data;
            fill_next      = '0;
            built_next     = 1'b0;
        end else if (cmd.restart) begin
            fill_next  = '0;
            built_next = 1'b0;
        end else begin
            if (cmd.fill_wr) begin
                fill_next = fill_reg + SW'(1);
            end
            if (cmd.set_built) begin
                built_next = 1'b1;
            end
        end
    end

    // shadow copy of entry 0
    always_comb begin
        root_next = root_reg;
        if (ram_we && (ram_waddr == '0)) begin
            root_next = $signed(ram_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_size_reg <= tnmh_pkg::HEAP_SIZE_RESET;
            fill_reg      <= '0;
            built_reg     <= 1'b0;
            heapify_reg   <= 1'b0;
        end else begin
            heap_size_reg <= heap_size_next;
            fill_reg      <= fill_next;
            built_reg     <= built_next;
            if (cmd.heap_init) begin
                heapify_reg <= 1'b1;
            end else if (cmd.sift_start) begin
                heapify_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        root_reg <= root_next;
        if (cmd.latch_in) begin
            op_reg     <= s_op;
            val_reg    <= s_value;
            idx_reg    <= s_read_index;
            acc_reg    <= 1'b0;
            rd_val_reg <= '0;
        end
        if (cmd.fill_wr || cmd.sift_start) begin
            acc_reg <= 1'b1;
        end
        if (cmd.rd_capture) begin
            if ((32'(idx_reg) < 32'(fill_reg)) && (32'(idx_reg) < tnmh_pkg::HEAP_DEPTH)) begin
                rd_val_reg <= kid_a;
            end else begin
                rd_val_reg <= '0;
            end
        end
        if (cmd.heap_init) begin
            k_reg <= AW'(n_half - SW'(1));
        end else if (cmd.k_dec) begin
            k_reg <= k_reg - AW'(1);
        end
        if (cmd.sift_start) begin
            held_reg <= val_reg;
            pos_reg  <= '0;
        end else if (cmd.cap_held) begin
            held_reg <= kid_a;
            pos_reg  <= k_reg;
        end else if (cmd.child_step) begin
            pos_reg <= child_pos;
        end
        if (cmd.load_out) begin
            out_rd_reg    <= rd_val_reg;
            out_acc_reg   <= acc_reg;
            out_min_reg   <= (fill_reg != '0) ? root_reg : '0;
            out_ready_reg <= built_reg;
        end
    end

    assign status.op        = op_reg;
    assign status.built     = built_reg;
    assign status.fill_last = (fill_reg + SW'(1)) >= n_used;
    assign status.size_ge2  = n_used >= SW'(2);
    assign status.greater   = val_reg > root_reg;
    assign status.kid_ok    = kid_l < {1'b0, n_used};
    assign status.child_lt  = child_val < held_reg;
    assign status.k_zero    = k_reg == '0;
    assign status.heapify   = heapify_reg;

    assign m_read_value = out_rd_reg;
    assign m_accepted   = out_acc_reg;
    assign m_heap_min   = out_min_reg;
    assign m_heap_ready = out_ready_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= n_used)
        else $error("fill count beyond size in use");

    a_built_full: assert property (@(posedge aclk) disable iff (!aresetn)
        built_reg |-> (fill_reg == n_used))
        else $error("heap built while not full");
`endif

endmodule

FILE: rtl/tnmh_ctrl.sv
// Controller: operation sequencing, heapify and sift-down walk, result handshake.
module tnmh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  tnmh_pkg::status_t status,
    output tnmh_pkg::cmd_t    cmd
);

    tnmh_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tnmh_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tnmh_pkg::ST_DECODE;
                end
            end
            tnmh_pkg::ST_DECODE: begin
                unique case (status.op)
                    tnmh_pkg::OP_OFFER: begin
                        if (!status.built && status.fill_last && status.size_ge2) begin
                            state_next = tnmh_pkg::ST_HLOAD;
                        end else if (status.built && status.greater) begin
                            state_next = tnmh_pkg::ST_SIFT_RD;
                        end else begin
                            state_next = tnmh_pkg::ST_DONE;
                        end
                    end
                    tnmh_pkg::OP_READ: state_next = tnmh_pkg::ST_RD_WAIT;
                    default:           state_next = tnmh_pkg::ST_DONE;
                endcase
            end
            tnmh_pkg::ST_RD_WAIT: state_next = tnmh_pkg::ST_DONE;
            tnmh_pkg::ST_HLOAD:   state_next = tnmh_pkg::ST_HCAP;
            tnmh_pkg::ST_HCAP:    state_next = tnmh_pkg::ST_SIFT_RD;
            tnmh_pkg::ST_SIFT_RD: begin
                state_next = status.kid_ok ? tnmh_pkg::ST_SIFT_CMP : tnmh_pkg::ST_SIFT_END;
            end
            tnmh_pkg::ST_SIFT_CMP: begin
                state_next = status.child_lt ? tnmh_pkg::ST_SIFT_RD : tnmh_pkg::ST_SIFT_END;
            end
            tnmh_pkg::ST_SIFT_END: begin
                if (status.heapify && !status.k_zero) begin
                    state_next = tnmh_pkg::ST_HLOAD;
                end else begin
                    state_next = tnmh_pkg::ST_DONE;
                end
            end
            tnmh_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = tnmh_pkg::ST_IDLE;
                end
            end
            default: state_next = tnmh_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            tnmh_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
            end
            tnmh_pkg::ST_DECODE: begin
                unique case (status.op)
                    tnmh_pkg::OP_OFFER: begin
                        cmd.fill_wr    = !status.built;
                        cmd.set_built  = !status.built && status.fill_last;
                        cmd.heap_init  = !status.built && status.fill_last && status.size_ge2;
                        cmd.sift_start = status.built && status.greater;
                    end
                    tnmh_pkg::OP_READ:    cmd.rd_issue = 1'b1;
                    tnmh_pkg::OP_RESTART: cmd.restart  = 1'b1;
                    default: ;
                endcase
            end
            tnmh_pkg::ST_RD_WAIT: cmd.rd_capture  = 1'b1;
            tnmh_pkg::ST_HLOAD:   cmd.load_read_k = 1'b1;
            tnmh_pkg::ST_HCAP:    cmd.cap_held    = 1'b1;
            tnmh_pkg::ST_SIFT_RD: begin
                // leaf reached: the held word settles here
                cmd.kid_issue = status.kid_ok;
                cmd.leaf_wr   = !status.kid_ok;
            end
            tnmh_pkg::ST_SIFT_CMP: begin
                cmd.child_step = status.child_lt;
                cmd.leaf_wr    = !status.child_lt;
            end
            tnmh_pkg::ST_SIFT_END: begin
                cmd.k_dec = status.heapify && !status.k_zero;
            end
            tnmh_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tnmh_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while one is in progress");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == tnmh_pkg::ST_DONE))
        else $error("result raised outside completion");

    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tnmh_pkg::ST_DONE && m_valid && !m_ready)
        |=> (state_reg == tnmh_pkg::ST_DONE))
        else $error("result overwritten while stalled");
`endif

endmodule

FILE: rtl/top_n_min_heap_core.sv
// Top level of the top-N min-heap core: keeps the largest signed words of a stream.
//
// Input channel s_*: one word carries s_op (offer, read entry, restart), s_value and
// s_read_index. Result channel m_*: exactly one result word per input word, in order.
// Configuration: cfg_wr_en/cfg_wr_data write the heap size (saturated into 1..depth);
// the write also empties the heap. Write it only while the core is idle.
// Timing: one word is worked at a time. A restart, a filling offer or a dropped offer
// goes from decode straight to completion; a read first waits for the registered RAM read.
// An offer that enters a built heap walks the sift-down level by level (dual read of
// both children, then compare and write back). The offer that fills the heap also runs
// the bottom-up heapify, roughly size/2 sift-downs. The next word can be taken in the
// same cycle as the result appears.
// The result sits in an output register; the next input word is taken while it waits.
// If the receiver stalls, a finished word waits in its last state until the register
// frees. Reset (aresetn low, synchronous) empties the heap and sets the size to 512;
// the heap memory itself is not cleared, entries beyond the fill count read as zero.
module top_n_min_heap_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tnmh_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tnmh_pkg::OP_W-1:0]           s_op,
    input  logic signed [tnmh_pkg::DATA_W-1:0]  s_value,
    input  logic [tnmh_pkg::RIDX_W-1:0]         s_read_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tnmh_pkg::DATA_W-1:0]  m_read_value,
    output logic                                m_accepted,
    output logic signed [tnmh_pkg::DATA_W-1:0]  m_heap_min,
    output logic                                m_heap_ready
);

    tnmh_pkg::cmd_t    cmd;
    tnmh_pkg::status_t status;

    tnmh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tnmh_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_op         (s_op),
        .s_value      (s_value),
        .s_read_index (s_read_index),
        .cmd          (cmd),
        .status       (status),
        .m_read_value (m_read_value),
        .m_accepted   (m_accepted),
        .m_heap_min   (m_heap_min),
        .m_heap_ready (m_heap_ready)
    );

endmodule
